// ----- sv/assert_macros.svh -----
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/edfts_pkg.sv -----
`timescale 1ns / 1ps

package edfts_pkg;

  localparam int IDX_BITS       = 3;
  localparam int LEAF_COUNT     = 2 ** IDX_BITS;
  localparam int NODE_COUNT     = 2 * LEAF_COUNT - 1;
  localparam int MASK_BITS      = 8;
  localparam int NOW_BITS       = 48;
  localparam int IDLE_BITS      = 32;
  localparam int PERIOD_BITS    = 32;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [MASK_BITS-1:0] FREQ_MASK_RESET = 8'hFF;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PERIOD_0_1 = 3'd0,
    CFG_PERIOD_2_3 = 3'd1,
    CFG_PERIOD_4_5 = 3'd2,
    CFG_PERIOD_6_7 = 3'd3,
    CFG_FREQ_MASK  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                none;
    logic [IDX_BITS-1:0] index;
  } sel_t;

endpackage

// ----- sv/edf_task_selector_unit.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Earliest-deadline-first task selector. Each request (alive mask, time stamp,
// idle time) refreshes the remaining deadline of every task and returns the
// alive task with the smallest remaining deadline, compared as a signed value
// so overdue tasks win; ties go to the lower index. One request is taken every
// cycle unless res_ready holds back the result; each passes through an input
// register, the per-task deadline update into the deadline registers, then an
// eight-leaf compare tree into the result register. With no task alive,
// none_alive is 1 and task_index and freq_high are 0. Registers 0 to 3 hold
// two 32-bit periods each (even task in the low half), register 4 the
// per-task high-frequency mask; write them only while no request is in flight.
module edf_task_selector_unit #(
  parameter int TASK_COUNT = 8,
  parameter int TIME_BITS  = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic [edfts_pkg::MASK_BITS-1:0]      alive_mask,
  input  logic [edfts_pkg::NOW_BITS-1:0]       now_us,
  input  logic [edfts_pkg::IDLE_BITS-1:0]      idle_time_us,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic [edfts_pkg::IDX_BITS-1:0]       task_index,
  output logic                                 none_alive,
  output logic                                 freq_high,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [edfts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [edfts_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic                              s1_valid;
  logic [TASK_COUNT-1:0]             s1_alive;
  logic [TIME_BITS-1:0]              s1_now;
  logic                              s1_idle;
  logic                              s2_valid;
  logic                              s2_load;
  logic                              res_load;
  logic [edfts_pkg::PERIOD_BITS-1:0] period [TASK_COUNT];
  logic [edfts_pkg::MASK_BITS-1:0]   freq_mask;
  logic [TIME_BITS-1:0]              deadline [TASK_COUNT];
  logic [TASK_COUNT-1:0]             prev_alive;
  edfts_pkg::sel_t                   sel;

  assign cfg_ready = 1'b1;
  assign res_load  = s2_valid && (!res_valid || res_ready);
  assign s2_load   = s1_valid && (!s2_valid || res_load);
  assign req_ready = !s1_valid || s2_load;

  edfts_cfg #(
    .TASK_COUNT(TASK_COUNT)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr       (cfg_valid && cfg_ready),
    .index    (cfg_index),
    .data     (cfg_data),
    .period   (period),
    .freq_mask(freq_mask)
  );

  edfts_update #(
    .TASK_COUNT(TASK_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .load      (s2_load),
    .alive     (s1_alive),
    .now       (s1_now),
    .idle      (s1_idle),
    .period    (period),
    .deadline  (deadline),
    .prev_alive(prev_alive)
  );

  // the alive mask of the item in stage 2 is the one just stored as prev_alive
  edfts_select #(
    .TASK_COUNT(TASK_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_select (
    .alive   (prev_alive),
    .deadline(deadline),
    .sel     (sel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_alive <= alive_mask[TASK_COUNT-1:0];
      s1_now   <= TIME_BITS'(now_us);
      s1_idle  <= |idle_time_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (res_load) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      task_index <= sel.index;
      none_alive <= sel.none;
      freq_high  <= !sel.none && freq_mask[sel.index];
    end
  end

  `ASSERT_IMPLIES(a_none_clean, clk, rst, res_valid && none_alive, task_index == '0 && !freq_high)
  `ASSERT_IMPLIES(a_index_range, clk, rst, res_valid && !none_alive, int'(task_index) < TASK_COUNT)
  `ASSERT_NEXT(a_res_load, clk, rst, res_load, res_valid)
  `ASSERT_IMPLIES(a_ready_full, clk, rst, !req_ready, s1_valid && s2_valid)

endmodule

// ----- sv/edfts_cfg.sv -----
`timescale 1ns / 1ps

module edfts_cfg #(
  parameter int TASK_COUNT = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    wr,
  input  logic [edfts_pkg::CFG_INDEX_BITS-1:0]    index,
  input  logic [edfts_pkg::CFG_DATA_BITS-1:0]     data,
  output logic [edfts_pkg::PERIOD_BITS-1:0]       period [TASK_COUNT],
  output logic [edfts_pkg::MASK_BITS-1:0]         freq_mask
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < TASK_COUNT; t++) begin
        period[t] <= '0;
      end
      freq_mask <= edfts_pkg::FREQ_MASK_RESET;
    end else if (wr) begin
      unique case (edfts_pkg::cfg_reg_t'(index))
        edfts_pkg::CFG_PERIOD_0_1, edfts_pkg::CFG_PERIOD_2_3,
        edfts_pkg::CFG_PERIOD_4_5, edfts_pkg::CFG_PERIOD_6_7: begin
          for (int t = 0; t < TASK_COUNT; t++) begin
            if (2'(t >> 1) == index[1:0]) begin
              period[t] <= data[edfts_pkg::PERIOD_BITS * (t % 2) +: edfts_pkg::PERIOD_BITS];
            end
          end
        end
        edfts_pkg::CFG_FREQ_MASK: begin
          freq_mask <= data[edfts_pkg::MASK_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/edfts_update.sv -----
`timescale 1ns / 1ps

module edfts_update #(
  parameter int TASK_COUNT = 8,
  parameter int TIME_BITS  = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [TASK_COUNT-1:0]             alive,
  input  logic [TIME_BITS-1:0]              now,
  input  logic                              idle,
  input  logic [edfts_pkg::PERIOD_BITS-1:0] period [TASK_COUNT],
  output logic [TIME_BITS-1:0]              deadline [TASK_COUNT],
  output logic [TASK_COUNT-1:0]             prev_alive
);

  logic [TIME_BITS-1:0] prev_time;
  logic                 have_prev;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] deadline_next [TASK_COUNT];

  assign elapsed = have_prev ? now - prev_time : '0;

  always_comb begin
    for (int t = 0; t < TASK_COUNT; t++) begin
      if (!alive[t]) begin
        deadline_next[t] = '0;
      end else if (prev_alive[t] && !idle) begin
        deadline_next[t] = deadline[t] - elapsed;
      end else begin
        deadline_next[t] = TIME_BITS'(period[t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < TASK_COUNT; t++) begin
        deadline[t] <= '0;
      end
      prev_alive <= '0;
      prev_time  <= '0;
      have_prev  <= 1'b0;
    end else if (load) begin
      for (int t = 0; t < TASK_COUNT; t++) begin
        deadline[t] <= deadline_next[t];
      end
      prev_alive <= alive;
      prev_time  <= now;
      have_prev  <= 1'b1;
    end
  end

endmodule

// ----- sv/edfts_select.sv -----
`timescale 1ns / 1ps

module edfts_select #(
  parameter int TASK_COUNT = 8,
  parameter int TIME_BITS  = 48
) (
  input  logic [TASK_COUNT-1:0] alive,
  input  logic [TIME_BITS-1:0]  deadline [TASK_COUNT],
  output edfts_pkg::sel_t       sel
);

  localparam int LEAVES = edfts_pkg::LEAF_COUNT;
  localparam int NODES  = edfts_pkg::NODE_COUNT;
  localparam logic [TIME_BITS-1:0] SIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

  logic                              leaf_v [LEAVES];
  logic [TIME_BITS-1:0]              leaf_k [LEAVES];
  logic                              node_v [NODES];
  logic [TIME_BITS-1:0]              node_k [NODES];
  logic [edfts_pkg::IDX_BITS-1:0]    node_i [NODES];

  // offset-binary key turns signed order into unsigned order
  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < TASK_COUNT) begin : g_task
      assign leaf_v[g] = alive[g];
      assign leaf_k[g] = deadline[g] ^ SIGN;
    end else begin : g_pad
      assign leaf_v[g] = 1'b0;
      assign leaf_k[g] = '0;
    end
  end

  // heap order: pair 2n, 2n+1 feeds node LEAVES+n, ties keep the lower index
  always_comb begin
    for (int n = 0; n < LEAVES; n++) begin
      node_v[n] = leaf_v[n];
      node_k[n] = leaf_k[n];
      node_i[n] = edfts_pkg::IDX_BITS'(n);
    end
    for (int n = 0; n < LEAVES - 1; n++) begin
      if (node_v[2*n+1] && (!node_v[2*n] || node_k[2*n+1] < node_k[2*n])) begin
        node_v[LEAVES+n] = 1'b1;
        node_k[LEAVES+n] = node_k[2*n+1];
        node_i[LEAVES+n] = node_i[2*n+1];
      end else begin
        node_v[LEAVES+n] = node_v[2*n];
        node_k[LEAVES+n] = node_k[2*n];
        node_i[LEAVES+n] = node_i[2*n];
      end
    end
  end

  assign sel.none  = !node_v[NODES-1];
  assign sel.index = node_v[NODES-1] ? node_i[NODES-1] : '0;

endmodule

// ----- dv/edf_task_selector_unit_tb.sv -----
`timescale 1ns / 1ps

module edf_task_selector_unit_tb;

  localparam int TASKS         = 8;
  localparam int TBITS         = 48;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 250;

  localparam int CFG_FIRST_UNUSED = int'(edfts_pkg::CFG_FREQ_MASK) + 1;
  localparam int CFG_LAST_INDEX   = 2 ** edfts_pkg::CFG_INDEX_BITS - 1;

  typedef struct packed {
    logic [edfts_pkg::MASK_BITS-1:0] alive;
    logic [edfts_pkg::NOW_BITS-1:0]  now;
    logic [edfts_pkg::IDLE_BITS-1:0] idle;
  } sched_req_t;

  typedef struct packed {
    logic [edfts_pkg::IDX_BITS-1:0] index;
    logic                           none;
    logic                           freq;
  } sched_pick_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_LONG} rx_mode_t;
  typedef enum int {SCALE_TINY, SCALE_SHORT, SCALE_WIDE, SCALE_EXTREME} scale_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                 req_valid    = 1'b0;
  logic                                 req_ready;
  logic [edfts_pkg::MASK_BITS-1:0]      alive_mask   = '0;
  logic [edfts_pkg::NOW_BITS-1:0]       now_us       = '0;
  logic [edfts_pkg::IDLE_BITS-1:0]      idle_time_us = '0;
  logic                                 res_valid;
  logic                                 res_ready    = 1'b0;
  logic [edfts_pkg::IDX_BITS-1:0]       task_index;
  logic                                 none_alive;
  logic                                 freq_high;
  logic                                 cfg_valid    = 1'b0;
  logic                                 cfg_ready;
  logic [edfts_pkg::CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [edfts_pkg::CFG_DATA_BITS-1:0]  cfg_data     = '0;

  always #6 clk = ~clk;

  edf_task_selector_unit #(
    .TASK_COUNT(TASKS),
    .TIME_BITS (TBITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .alive_mask  (alive_mask),
    .now_us      (now_us),
    .idle_time_us(idle_time_us),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .task_index  (task_index),
    .none_alive  (none_alive),
    .freq_high   (freq_high),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // scheduler state as the testbench sees it
  logic [TBITS-1:0]                    deadline_left [TASKS];
  logic [edfts_pkg::MASK_BITS-1:0]     last_alive;
  logic [TBITS-1:0]                    last_now;
  logic                                have_last_now;
  logic [edfts_pkg::CFG_DATA_BITS-1:0] period_reg [4];
  logic [edfts_pkg::MASK_BITS-1:0]     freq_pref;

  sched_req_t  requests_todo [$];
  sched_pick_t picks_due [$];

  int unsigned requests_queued   = 0;
  int unsigned requests_accepted = 0;
  int unsigned picks_checked     = 0;
  int unsigned idle_picks        = 0;
  int unsigned overdue_picks     = 0;
  int unsigned reg_writes        = 0;
  int unsigned mismatches        = 0;
  int unsigned quiet_cycles      = 0;

  logic [edfts_pkg::NOW_BITS-1:0]  stream_now   = '0;
  logic [edfts_pkg::MASK_BITS-1:0] stream_alive = '0;

  function automatic sched_pick_t edf_pick(input sched_req_t req);
    logic [TBITS-1:0]                  elapsed;
    logic [edfts_pkg::PERIOD_BITS-1:0] period;
    logic signed [TBITS-1:0]           best_left;
    sched_pick_t                       pick;
    int                                best;
    bit                                found;
    int                                t;
    elapsed = have_last_now ? req.now[TBITS-1:0] - last_now : '0;
    last_now = req.now[TBITS-1:0];
    have_last_now = 1'b1;
    found = 1'b0;
    best = 0;
    best_left = '0;
    for (t = 0; t < TASKS; t++) begin
      period = period_reg[t / 2][(t % 2) * edfts_pkg::PERIOD_BITS +: edfts_pkg::PERIOD_BITS];
      if (!req.alive[t]) begin
        deadline_left[t] = '0;
      end else if (last_alive[t] && req.idle == '0) begin
        deadline_left[t] = deadline_left[t] - elapsed;
      end else begin
        deadline_left[t] = TBITS'(period);
      end
      // strict compare keeps ties on the lowest index
      if (req.alive[t] && (!found || $signed(deadline_left[t]) < best_left)) begin
        found = 1'b1;
        best = t;
        best_left = deadline_left[t];
      end
    end
    last_alive = req.alive;
    if (found && best_left < 0) overdue_picks++;
    pick.none = !found;
    pick.index = found ? edfts_pkg::IDX_BITS'(best) : '0;
    pick.freq = found ? freq_pref[best] : 1'b0;
    return pick;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("[%0t] result %0d: %s got %0d expected %0d", $time, picks_checked, what, got,
             want);
  endtask

  task automatic push_request(input logic [edfts_pkg::MASK_BITS-1:0] alive,
                              input logic [edfts_pkg::NOW_BITS-1:0] now,
                              input logic [edfts_pkg::IDLE_BITS-1:0] idle);
    sched_req_t req;
    req.alive = alive;
    req.now = now;
    req.idle = idle;
    requests_todo.push_back(req);
    requests_queued++;
  endtask

  task automatic write_reg(input logic [edfts_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [edfts_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (requests_accepted != requests_queued || picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [edfts_pkg::PERIOD_BITS-1:0] pick_period(input scale_t scale);
    case (scale)
      SCALE_TINY:  return $urandom_range(0, 3) * 50;
      SCALE_SHORT: return $urandom_range(0, 2000);
      SCALE_WIDE:  return $urandom;
      default: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  function automatic logic [edfts_pkg::NOW_BITS-1:0] pick_step(input scale_t scale);
    case (scale)
      SCALE_TINY:  return edfts_pkg::NOW_BITS'($urandom_range(0, 60));
      SCALE_SHORT: return edfts_pkg::NOW_BITS'($urandom_range(0, 300));
      SCALE_WIDE:  return edfts_pkg::NOW_BITS'($urandom);
      default:     return edfts_pkg::NOW_BITS'({$urandom, $urandom});
    endcase
  endfunction

  // driver: bursts of items with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    sched_req_t next_req;
    if (rst) begin
      req_valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else if (!req_valid || req_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (requests_todo.size() != 0) begin
        next_req = requests_todo.pop_front();
        req_valid <= 1'b1;
        alive_mask <= next_req.alive;
        now_us <= next_req.now;
        idle_time_us <= next_req.idle;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // monitor: predicts on accepted items, checks results, drives the stall pattern
  rx_mode_t    rx_mode  = RX_OPEN;
  int unsigned rx_cycle = 0;

  always @(posedge clk) begin
    sched_req_t  seen_req;
    sched_pick_t got;
    sched_pick_t want;
    int          t;
    if (rst) begin
      for (t = 0; t < TASKS; t++) deadline_left[t] = '0;
      for (t = 0; t < 4; t++) period_reg[t] = '0;
      freq_pref = edfts_pkg::FREQ_MASK_RESET;
      last_alive = '0;
      last_now = '0;
      have_last_now = 1'b0;
      res_ready <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (res_valid && res_ready) begin
        got.index = task_index;
        got.none = none_alive;
        got.freq = freq_high;
        if (picks_due.size() == 0) begin
          report_mismatch("result with nothing pending, task_index", got.index, 0);
        end else begin
          want = picks_due.pop_front();
          if (got.index !== want.index) report_mismatch("task_index", got.index, want.index);
          if (got.none !== want.none) report_mismatch("none_alive", got.none, want.none);
          if (got.freq !== want.freq) report_mismatch("freq_high", got.freq, want.freq);
          if (want.none) idle_picks++;
        end
        picks_checked++;
      end
      if (req_valid && req_ready) begin
        seen_req.alive = alive_mask;
        seen_req.now = now_us;
        seen_req.idle = idle_time_us;
        picks_due.push_back(edf_pick(seen_req));
        requests_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          edfts_pkg::CFG_PERIOD_0_1, edfts_pkg::CFG_PERIOD_2_3,
          edfts_pkg::CFG_PERIOD_4_5, edfts_pkg::CFG_PERIOD_6_7:
            period_reg[cfg_index[1:0]] = cfg_data;
          edfts_pkg::CFG_FREQ_MASK: freq_pref = cfg_data[edfts_pkg::MASK_BITS-1:0];
          default: ;
        endcase
        reg_writes++;
      end
      if ((req_valid && req_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;

      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:  res_ready <= 1'b1;
        RX_COIN:  res_ready <= $urandom_range(0, 1);
        RX_THIRD: res_ready <= (rx_cycle % 3) == 0;
        default:  res_ready <= rx_cycle[4];
      endcase
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int     p;
    int     n;
    int     k;
    scale_t scale;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // registers still at their reset values, first request after reset
    push_request(8'h00, 48'h0, 32'h0);
    push_request(8'hFF, 48'hFFFF_FFFF_FFFF, 32'h0);
    push_request(8'h00, 48'hFFFF_FFFF_FFFF, 32'h0);
    drain();

    write_reg(edfts_pkg::CFG_PERIOD_0_1, {32'd300, 32'd500});
    write_reg(edfts_pkg::CFG_PERIOD_2_3, {32'hFFFF_FFFF, 32'd300});
    write_reg(edfts_pkg::CFG_PERIOD_4_5, {32'd1000, 32'd0});
    write_reg(edfts_pkg::CFG_PERIOD_6_7, {32'd7, 32'd300});
    write_reg(edfts_pkg::CFG_FREQ_MASK, 64'hFFFF_FFFF_FFFF_FFA6);
    for (k = CFG_FIRST_UNUSED; k <= CFG_LAST_INDEX; k++)
      write_reg(k[edfts_pkg::CFG_INDEX_BITS-1:0], {$urandom, $urandom});

    push_request(8'h06, 48'd5, 32'h0);                      // clock wrap, tie on period
    push_request(8'h06, 48'd105, 32'h0);
    push_request(8'h0E, 48'd110, 32'h0);
    push_request(8'h0E, 48'd500, 32'h0);                    // overdue tasks
    push_request(8'h0C, 48'd510, 32'h0);
    push_request(8'h0C, 48'd520, 32'h1);                    // idle forces reload
    push_request(8'h81, 48'd530, 32'hFFFF_FFFF);
    push_request(8'h81, 48'd400, 32'h0);                    // clock goes backwards
    push_request(8'h10, 48'd400, 32'h0);
    push_request(8'hFF, 48'd400, 32'h0);
    push_request(8'h00, 48'd410, 32'h0);
    push_request(8'h60, 48'h1000, 32'h0);
    push_request(8'h60, 48'h1000 + 48'h8000_0000_01F4, 32'h0); // crosses the sign boundary
    push_request(8'hFF, 48'hFFFF_FFFF_FFFF, 32'h0);
    push_request(8'hFF, 48'h3, 32'h0);
    drain();

    for (k = 0; k < 4; k++) write_reg(k[edfts_pkg::CFG_INDEX_BITS-1:0], '1);
    write_reg(edfts_pkg::CFG_FREQ_MASK, '0);
    push_request(8'h55, 48'd100, 32'h1);
    push_request(8'hAA, 48'd200, 32'h0);
    push_request(8'hAA, 48'd300, 32'h0);
    drain();

    for (p = 0; p < PHASES; p++) begin
      scale = scale_t'($urandom_range(0, 3));
      for (k = 0; k < 4; k++)
        write_reg(k[edfts_pkg::CFG_INDEX_BITS-1:0], {pick_period(scale), pick_period(scale)});
      write_reg(edfts_pkg::CFG_FREQ_MASK,
                p == 0 ? 64'h0 : p == 1 ? 64'hFF : {$urandom, $urandom});
      write_reg(edfts_pkg::CFG_INDEX_BITS'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX)),
                {$urandom, $urandom});
      stream_alive = edfts_pkg::MASK_BITS'($urandom);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        k = $urandom_range(0, 99);
        if (k < 80) begin
          // steady task set with time moving forward
          if ($urandom_range(0, 3) == 0) stream_alive ^= 8'b1 << $urandom_range(0, 7);
          stream_now += pick_step(scale);
          push_request(stream_alive, stream_now,
                       ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'h0);
        end else if (k < 95) begin
          push_request(edfts_pkg::MASK_BITS'($urandom),
                       edfts_pkg::NOW_BITS'({$urandom, $urandom}),
                       ($urandom_range(0, 1) == 0) ? 32'h0 : 32'($urandom));
        end else begin
          stream_now -= edfts_pkg::NOW_BITS'($urandom_range(0, 1000));
          stream_alive = edfts_pkg::MASK_BITS'($urandom);
          push_request(stream_alive, stream_now, 32'h0);
        end
      end
      drain();
    end

    $display("covered %0d scheduling requests and %0d register writes, unused indexes included",
             requests_accepted, reg_writes);
    $display("%0d results checked: %0d with no task alive, %0d picking an overdue task",
             picks_checked, idle_picks, overdue_picks);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
